// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gnnw_pkg.sv =====
// Shared types, constants and the control store of the greedy walk engine.
// Depends on nothing; used by every other RTL file of the block but gnnw_ram and assert_macros.svh.
package gnnw_pkg;

  // Default sizes of the matrix store.
  localparam int MAX_NODES_DEF   = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths of the channels and the register.
  localparam int KIND_W   = 1;
  localparam int NODE_FW  = 4;
  localparam int WEIGHT_W = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_START = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_MOVED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ARRIVED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REVISIT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DEADEND = 2'd3;

  // Microprogram step addresses.
  localparam int STEP_W = 4;
  typedef enum logic [STEP_W-1:0] {
    U_IDLE,
    U_CHECK,
    U_ROW,
    U_SCAN,
    U_HITCHK,
    U_CHOSEN,
    U_SEEN,
    U_MOVE,
    U_ARRIVE,
    U_DEAD,
    U_REVISIT
  } step_t;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROW_INIT,
    OP_SCAN,
    OP_MOVE
  } op_t;

  // Jump conditions; a true condition jumps to the target, else fall through.
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_START,
    C_START_OUT,
    C_SCAN_MORE,
    C_HIT,
    C_NOT_CHOSEN,
    C_VISITED
  } cond_t;

  // Source of the node field of an emitted result.
  typedef enum logic [1:0] {
    NS_GOAL,
    NS_CUR,
    NS_BEST
  } nsrc_t;

  // One control word.
  typedef struct packed {
    logic                accept;
    op_t                 op;
    cond_t               cond;
    step_t               target;
    logic                emit;
    nsrc_t               nsrc;
    logic [STATUS_W-1:0] status;
    logic                last;
  } ctrl_t;

  // Flags returned by the datapath to the sequencer.
  typedef struct packed {
    logic go;
    logic start_acc;
    logic start_out;
    logic scan_more;
    logic hit;
    logic chosen;
    logic seen;
  } dpstat_t;

  // Control store: one word per step.
  function automatic ctrl_t ucode_rom(step_t step);
    ctrl_t w;
    w        = '0;
    w.op     = OP_NONE;
    w.cond   = C_NONE;
    w.target = U_IDLE;
    w.nsrc   = NS_CUR;
    w.status = ST_MOVED;
    case (step)
      U_IDLE: begin
        w.accept = 1'b1;
        w.op     = OP_LOAD;
        w.cond   = C_NOT_START;
        w.target = U_IDLE;
      end
      U_CHECK: begin
        w.cond   = C_START_OUT;
        w.target = U_DEAD;
      end
      U_ROW: begin
        w.op = OP_ROW_INIT;
      end
      U_SCAN: begin
        w.op     = OP_SCAN;
        w.cond   = C_SCAN_MORE;
        w.target = U_SCAN;
      end
      U_HITCHK: begin
        w.cond   = C_HIT;
        w.target = U_ARRIVE;
      end
      U_CHOSEN: begin
        w.cond   = C_NOT_CHOSEN;
        w.target = U_DEAD;
      end
      U_SEEN: begin
        w.cond   = C_VISITED;
        w.target = U_REVISIT;
      end
      U_MOVE: begin
        w.op     = OP_MOVE;
        w.emit   = 1'b1;
        w.nsrc   = NS_BEST;
        w.status = ST_MOVED;
        w.cond   = C_ALWAYS;
        w.target = U_ROW;
      end
      U_ARRIVE: begin
        w.emit   = 1'b1;
        w.nsrc   = NS_GOAL;
        w.status = ST_ARRIVED;
        w.last   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_DEAD: begin
        w.emit   = 1'b1;
        w.nsrc   = NS_CUR;
        w.status = ST_DEADEND;
        w.last   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_REVISIT: begin
        w.emit   = 1'b1;
        w.nsrc   = NS_BEST;
        w.status = ST_REVISIT;
        w.last   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/gnnw_in_if.sv =====
// Input channel: load and start beats with valid/ready handshake.
// Depends on gnnw_pkg for field widths.
interface gnnw_in_if;
  logic                                valid;
  logic                                ready;
  logic [gnnw_pkg::KIND_W-1:0]         kind;
  logic [gnnw_pkg::NODE_FW-1:0]        row;
  logic [gnnw_pkg::NODE_FW-1:0]        col;
  logic signed [gnnw_pkg::WEIGHT_W-1:0] weight;
  logic [gnnw_pkg::NODE_FW-1:0]        start_node;
  logic [gnnw_pkg::NODE_FW-1:0]        goal_node;

  modport source (output valid, kind, row, col, weight, start_node, goal_node, input ready);
  modport sink (input valid, kind, row, col, weight, start_node, goal_node, output ready);
endinterface

// ===== hw/rtl/gnnw_out_if.sv =====
// Result channel: one beat per walk step with valid/ready handshake.
// Depends on gnnw_pkg for field widths.
interface gnnw_out_if;
  logic                          valid;
  logic                          ready;
  logic [gnnw_pkg::NODE_FW-1:0]  node;
  logic [gnnw_pkg::STATUS_W-1:0] status;
  logic                          last;

  modport source (output valid, node, status, last, input ready);
  modport sink (input valid, node, status, last, output ready);
endinterface

// ===== hw/rtl/greedy_nearest_neighbor_walk.sv =====
// Greedy nearest-neighbor walk over a weight matrix held in one RAM.
// Load beats are taken one per cycle while the sequencer is idle; the row scan
// reads one matrix entry per cycle, over the nodes in use, through the single
// read port.
// Reset (synchronous, active low) returns the sequencer to idle, clears the
// visited set and result valid, and sets node_count to 16; the matrix is kept.
`include "assert_macros.svh"

module greedy_nearest_neighbor_walk #(
  parameter int MAX_NODES   = gnnw_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = gnnw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gnnw_in_if.sink                    in_ch,
  gnnw_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [gnnw_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);

  logic [gnnw_pkg::CFG_W-1:0] node_count_r;
  logic [CNT_W-1:0]           nc;
  gnnw_pkg::ctrl_t            ctrl;
  gnnw_pkg::dpstat_t          st;

  // Node count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= gnnw_pkg::CFG_RESET;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // Counts above the matrix size act as the matrix size.
  assign nc = (int'(node_count_r) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count_r);

  gnnw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctrl  (ctrl)
  );

  gnnw_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .st     (st),
    .nc     (nc),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // A search in flight takes no new input beat until its final result.
  `ASSERT_IMP(a_no_accept_mid_walk, out_ch.valid && !out_ch.last, !in_ch.ready, "input taken mid walk")
  // A result is final exactly when its status is not a move.
  `ASSERT_IMP(a_last_matches_status, out_ch.valid, out_ch.last == (out_ch.status != gnnw_pkg::ST_MOVED), "last flag does not match status")
  // Accepting a start beat leaves the idle step.
  `ASSERT_NXT(a_start_leaves_idle, in_ch.valid && in_ch.ready && in_ch.kind == gnnw_pkg::KIND_START, !in_ch.ready, "still ready after start")

endmodule

// ===== hw/rtl/gnnw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gnnw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/gnnw_seq.sv =====
// Microprogram sequencer: step counter, control store fetch and jumps.
// Depends on gnnw_pkg for the control word, step and condition types.
module gnnw_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  gnnw_pkg::dpstat_t st,
  output gnnw_pkg::ctrl_t   ctrl
);

  localparam int STEP_W = gnnw_pkg::STEP_W;

  gnnw_pkg::step_t upc_r;
  gnnw_pkg::step_t upc_nxt;
  logic            take;

  // Control word of the current step.
  always_comb begin
    ctrl = gnnw_pkg::ucode_rom(upc_r);
  end

  // Jump condition and next step; a stalled step holds.
  always_comb begin
    case (ctrl.cond)
      gnnw_pkg::C_NONE:       take = 1'b0;
      gnnw_pkg::C_ALWAYS:     take = 1'b1;
      gnnw_pkg::C_NOT_START:  take = !st.start_acc;
      gnnw_pkg::C_START_OUT:  take = st.start_out;
      gnnw_pkg::C_SCAN_MORE:  take = st.scan_more;
      gnnw_pkg::C_HIT:        take = st.hit;
      gnnw_pkg::C_NOT_CHOSEN: take = !st.chosen;
      gnnw_pkg::C_VISITED:    take = st.seen;
      default:                take = 1'b1;
    endcase
    upc_nxt = upc_r;
    if (st.go) begin
      upc_nxt = take ? ctrl.target : gnnw_pkg::step_t'(upc_r + STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= gnnw_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== hw/rtl/gnnw_dp.sv =====
// Walk datapath: matrix store, row scan, visited set and result register.
// Depends on gnnw_pkg, gnnw_in_if, gnnw_out_if and gnnw_ram.
module gnnw_dp #(
  parameter int MAX_NODES   = gnnw_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = gnnw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gnnw_pkg::ctrl_t                  ctrl,
  output gnnw_pkg::dpstat_t                st,
  input  logic [$clog2(MAX_NODES+1)-1:0]   nc,
  gnnw_in_if.sink                          in_ch,
  gnnw_out_if.source                       out_ch
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int OUT_W  = gnnw_pkg::NODE_FW;
  localparam int NODE_W = (IDX_W > OUT_W) ? IDX_W : OUT_W;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [NODE_W-1:0]             cur_r, cur_nxt;
  logic [OUT_W-1:0]              goal_r, goal_nxt;
  logic [CNT_W-1:0]              j_r, j_nxt;
  logic [IDX_W-1:0]              jd_r, jd_nxt;
  logic                          pv_r, pv_nxt;
  logic [IDX_W-1:0]              best_r, best_nxt;
  logic signed [WEIGHT_BITS-1:0] best_w_r, best_w_nxt;
  logic                          chosen_r, chosen_nxt;
  logic                          hit_r, hit_nxt;
  logic [MAX_NODES-1:0]          visited_r, visited_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]              out_node_r, out_node_nxt;
  logic [gnnw_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          go;
  logic                          in_acc;
  logic                          issue;
  logic                          scan_hit;
  logic                          better;
  logic signed [WEIGHT_BITS-1:0] w;
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [WEIGHT_BITS-1:0]        ram_wdata;
  logic [WEIGHT_BITS-1:0]        ram_rdata;

  // Handshake: a step that emits waits for the result register to free up.
  assign in_ch.ready = ctrl.accept;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign go          = !(ctrl.emit && out_valid_r && !out_ch.ready);

  // Matrix store, addressed by row and column; loads outside the matrix drop.
  assign ram_we    = in_acc && (in_ch.kind == gnnw_pkg::KIND_LOAD) &&
                     (int'(in_ch.row) < MAX_NODES) && (int'(in_ch.col) < MAX_NODES);
  assign ram_waddr = {IDX_W'(in_ch.row), IDX_W'(in_ch.col)};
  assign ram_wdata = WEIGHT_BITS'(in_ch.weight);
  assign ram_raddr = {IDX_W'(cur_r), j_r[IDX_W-1:0]};

  gnnw_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan compare on the entry read in the previous cycle.
  assign w        = $signed(ram_rdata);
  assign issue    = j_r < nc;
  assign scan_hit = pv_r && (w != '0) && (int'(jd_r) == int'(goal_r));
  assign better   = (w != '0) && (int'(jd_r) != int'(cur_r)) &&
                    ((best_w_r == '0) || (w < best_w_r));

  // Flags for the sequencer.
  always_comb begin
    st.go        = go;
    st.start_acc = in_acc && (in_ch.kind == gnnw_pkg::KIND_START);
    st.start_out = int'(cur_r) >= int'(nc);
    st.scan_more = (issue || pv_r) && !scan_hit;
    st.hit       = hit_r;
    st.chosen    = chosen_r;
    st.seen      = visited_r[best_r];
  end

  // Next-state logic of the datapath registers.
  always_comb begin
    cur_nxt        = cur_r;
    goal_nxt       = goal_r;
    j_nxt          = j_r;
    jd_nxt         = jd_r;
    pv_nxt         = pv_r;
    best_nxt       = best_r;
    best_w_nxt     = best_w_r;
    chosen_nxt     = chosen_r;
    hit_nxt        = hit_r;
    visited_nxt    = visited_r;
    out_valid_nxt  = out_valid_r;
    out_node_nxt   = out_node_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (go) begin
      // Result register load.
      if (ctrl.emit) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ctrl.status;
        out_last_nxt   = ctrl.last;
        case (ctrl.nsrc)
          gnnw_pkg::NS_GOAL: out_node_nxt = goal_r;
          gnnw_pkg::NS_BEST: out_node_nxt = OUT_W'(best_r);
          default:           out_node_nxt = OUT_W'(cur_r);
        endcase
      end

      case (ctrl.op)
        gnnw_pkg::OP_LOAD: begin
          if (in_acc && (in_ch.kind == gnnw_pkg::KIND_START)) begin
            cur_nxt     = NODE_W'(in_ch.start_node);
            goal_nxt    = in_ch.goal_node;
            visited_nxt = '0;
          end
        end
        gnnw_pkg::OP_ROW_INIT: begin
          j_nxt      = '0;
          pv_nxt     = 1'b0;
          best_nxt   = '0;
          chosen_nxt = 1'b0;
          hit_nxt    = 1'b0;
        end
        gnnw_pkg::OP_SCAN: begin
          // Issue the next read and judge the entry that came back.
          pv_nxt  = issue;
          hit_nxt = scan_hit;
          if (issue) begin
            j_nxt  = j_r + CNT_W'(1);
            jd_nxt = j_r[IDX_W-1:0];
          end
          if (pv_r && !scan_hit) begin
            // Column zero seeds the candidate weight without counting as a choice.
            if (jd_r == '0) begin
              best_w_nxt = w;
            end else if (better) begin
              best_nxt   = jd_r;
              best_w_nxt = w;
              chosen_nxt = 1'b1;
            end
          end
        end
        gnnw_pkg::OP_MOVE: begin
          visited_nxt[best_r] = 1'b1;
          cur_nxt             = NODE_W'(best_r);
        end
        default: begin
        end
      endcase
    end
  end

  // Control flags, the visited set, cur and best reset; other payload registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      hit_r       <= 1'b0;
      chosen_r    <= 1'b0;
      visited_r   <= '0;
      cur_r       <= '0;
      best_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      hit_r       <= hit_nxt;
      chosen_r    <= chosen_nxt;
      visited_r   <= visited_nxt;
      cur_r       <= cur_nxt;
      best_r      <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    goal_r       <= goal_nxt;
    j_r          <= j_nxt;
    jd_r         <= jd_nxt;
    best_w_r     <= best_w_nxt;
    out_node_r   <= out_node_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.node   = out_node_r;
  assign out_ch.status = out_status_r;
  assign out_ch.last   = out_last_r;

endmodule
